// ----- design/pcs_pkg.sv -----
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared widths, reset values and register indexes of the price confluence
// scorer.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int PRICE_W    = 24;
  localparam int VOL_W      = 24;
  localparam int TOL_W      = 12;
  localparam int ATRL_W     = 6;
  localparam int CNT_W      = 7;   // atr_length + 1, up to 64
  localparam int TRS_W      = 30;  // up to 64 true ranges of 24 bits
  localparam int MS_W       = TRS_W + TOL_W;
  localparam int FRAC_W     = 8;
  localparam int ATR_W      = 32;
  localparam int SCORE_W    = 2;
  localparam int DIF_W      = 26;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam int ATR_DEPTH_DEF = 64;
  localparam int VWAP_BARS_DEF = 51;

  localparam logic [ATRL_W-1:0] ATR_LEN_RST = 6'd14;
  localparam logic [TOL_W-1:0]  TOL_RST     = 12'd128;

  localparam logic [CFG_IDX_W-1:0] REG_ATR_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL     = 1'b1;

endpackage

// ----- design/pcs_ser_mul.sv -----
// ----------------------------------------------------------------------------
// pcs_ser_mul
// Shift-add multiplier, one multiplier bit per cycle, stops once the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module pcs_ser_mul import pcs_pkg::*; #(
  parameter int MA_W = PRICE_W + VOL_W + 6,
  parameter int MB_W = VOL_W + 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MA_W-1:0]      a_i,
  input  logic [MB_W-1:0]      b_i,
  output logic                 busy_o,
  output logic [MA_W+MB_W-1:0] prod_o
);

  localparam int P_W = MA_W + MB_W;

  logic           busy_q, busy_d;
  logic [P_W-1:0] a_q, a_d, acc_q, acc_d;
  logic [MB_W-1:0] b_q, b_d;

  always_comb begin
    busy_d = busy_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      a_d    = {{MB_W{1'b0}}, a_i};
      b_d    = b_i;
      acc_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d = {a_q[P_W-2:0], 1'b0};
        b_d = {1'b0, b_q[MB_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

// ----- design/pcs_ser_div.sv -----
// ----------------------------------------------------------------------------
// pcs_ser_div
// Restoring divider, one quotient bit per cycle: (sum << 8) / count.
// ----------------------------------------------------------------------------
module pcs_ser_div import pcs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [TRS_W+FRAC_W-1:0]   dividend_i,
  input  logic [CNT_W-1:0]          divisor_i,
  output logic                      busy_o,
  output logic [TRS_W+FRAC_W-1:0]   quot_o
);

  localparam int N_W  = TRS_W + FRAC_W;
  localparam int CT_W = $clog2(N_W + 1);

  logic             busy_q, busy_d;
  logic [CT_W-1:0]  cnt_q, cnt_d;
  logic [N_W-1:0]   q_q, q_d;
  logic [CNT_W-1:0] rem_q, rem_d, div_q, div_d;
  logic [CNT_W:0]   r, diff;
  logic             ge;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    q_d    = q_q;
    rem_d  = rem_q;
    div_d  = div_q;
    r      = {rem_q, q_q[N_W-1]};
    ge     = r >= {1'b0, div_q};
    diff   = r - {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CT_W'(N_W);
      q_d    = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[CNT_W-1:0] : r[CNT_W-1:0];
      q_d   = {q_q[N_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

endmodule

// ----- design/price_confluence_scorer.sv -----
// ----------------------------------------------------------------------------
// price_confluence_scorer
// ATR over a true range ring and a score of pivot, mid-range and VWAP
// references lying within tolerance * ATR of the close.
//
//   channel  signals                                   direction
//   in       in_valid_i/in_ready_o + 4 bar fields      to block
//   out      out_valid_o/out_ready_i + 5 result fields from block
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i         to block, no wait
//
// The shift-add multiplier handles one multiplier bit per cycle over seven
// products, and the true range sum reads one ring entry per cycle, up to
// atr_length+1 entries, fewer while fewer bars are stored.
// The first bar takes only the price-volume product and gives no result.
// in_ready_o is high only while idle. A finished result waits in the
// output register; the next one holds until that register is free.
// No clearing pass after reset: ring entries are read only once written.
// ----------------------------------------------------------------------------
module price_confluence_scorer import pcs_pkg::*; #(
  parameter int ATR_DEPTH = ATR_DEPTH_DEF,
  parameter int VWAP_BARS = VWAP_BARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PRICE_W-1:0]    high_price_i,
  input  logic [PRICE_W-1:0]    low_price_i,
  input  logic [PRICE_W-1:0]    close_price_i,
  input  logic [VOL_W-1:0]      bar_volume_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SCORE_W-1:0]    score_o,
  output logic [ATR_W-1:0]      atr_value_o,
  output logic                  near_pivot_o,
  output logic                  near_midrange_o,
  output logic                  near_vwap_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int TR_AW  = (ATR_DEPTH > 1) ? $clog2(ATR_DEPTH) : 1;
  localparam int VW_AW  = (VWAP_BARS > 1) ? $clog2(VWAP_BARS) : 1;
  localparam int BS_CAP = (ATR_DEPTH > VWAP_BARS) ? ATR_DEPTH : VWAP_BARS;
  localparam int BS_W   = $clog2(BS_CAP + 1);
  localparam int CC_W   = (BS_W > CNT_W) ? BS_W : CNT_W;
  localparam int VS_W   = VOL_W + $clog2(VWAP_BARS);
  localparam int PE_W   = PRICE_W + VOL_W;
  localparam int PV_W   = PRICE_W + VS_W;
  localparam int MA_W   = PV_W;
  localparam int MB_W   = VS_W;
  localparam int P_W    = MA_W + MB_W;
  localparam int CMP_W  = P_W + FRAC_W;
  localparam int N_W    = TRS_W + FRAC_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_SUM  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    OP_PV, OP_MSUM, OP_CV, OP_DP, OP_DM, OP_DV, OP_RV
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [ATRL_W-1:0]  atr_len_q;
  logic [TOL_W-1:0]   tol_q;

  logic [PRICE_W-1:0] h_q, h_d, l_q, l_d, c_q, c_d;
  logic [VOL_W-1:0]   v_q, v_d;
  logic [PRICE_W-1:0] ph_q, ph_d, pl_q, pl_d, pc_q, pc_d;
  logic [BS_W-1:0]    bs_q, bs_d;
  logic [TR_AW-1:0]   tr_wp_q, tr_wp_d, rd_ptr_q, rd_ptr_d;
  logic [VW_AW-1:0]   vw_pos_q, vw_pos_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, rd_left_q, rd_left_d;
  logic               pend_q, pend_d;
  logic [TRS_W-1:0]   sum_q, sum_d;
  logic [PV_W-1:0]    pv_q, pv_d, cv_q, cv_d;
  logic [VS_W-1:0]    vs_q, vs_d;
  logic [MS_W-1:0]    msum_q, msum_d;
  logic [P_W-1:0]     lv_q, lv_d;
  logic               np_q, np_d, nm_q, nm_d, nv_q, nv_d;

  logic               out_valid_q, out_valid_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic [ATR_W-1:0]   atr_q, atr_d;
  logic               onp_q, onp_d, onm_q, onm_d, onv_q, onv_d;

  logic [PRICE_W-1:0]      tr_mem [ATR_DEPTH];
  logic [PRICE_W-1:0]      tr_rd_q;
  logic [PE_W+VOL_W-1:0]   vw_mem [VWAP_BARS];
  logic [PE_W+VOL_W-1:0]   vw_rd_q;

  logic               accept, tr_we, tr_rd_en, vw_we;
  logic [PRICE_W-1:0] tr_val;
  logic [PRICE_W:0]   d_hl, d_hc, d_lc, a_hc, a_lc;
  logic [CC_W-1:0]    avail, len1, cnt_full;
  logic [DIF_W:0]     s3, pp, s2, hl;
  logic [DIF_W-1:0]   dp, dm;
  logic [PV_W-1:0]    dv;
  logic               full;

  logic               mul_go, mul_busy, div_go, div_busy;
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [P_W-1:0]     prod;
  logic [N_W-1:0]     quot;
  logic [MS_W+1:0]    m3;

  pcs_ser_mul #(.MA_W(MA_W), .MB_W(MB_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (prod)
  );

  pcs_ser_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i ({sum_q, {FRAC_W{1'b0}}}),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // true range of the incoming bar against the stored close
  always_comb begin
    d_hl   = {1'b0, high_price_i} - {1'b0, low_price_i};
    d_hc   = {1'b0, high_price_i} - {1'b0, pc_q};
    d_lc   = {1'b0, low_price_i} - {1'b0, pc_q};
    a_hc   = d_hc[PRICE_W] ? ({(PRICE_W+1){1'b0}} - d_hc) : d_hc;
    a_lc   = d_lc[PRICE_W] ? ({(PRICE_W+1){1'b0}} - d_lc) : d_lc;
    tr_val = (a_hc > a_lc) ? a_hc[PRICE_W-1:0] : a_lc[PRICE_W-1:0];
    if (!d_hl[PRICE_W] && (d_hl[PRICE_W-1:0] > tr_val)) begin
      tr_val = d_hl[PRICE_W-1:0];
    end
  end

  always_comb begin
    avail    = (CC_W'(bs_q) < CC_W'(ATR_DEPTH)) ? CC_W'(bs_q) : CC_W'(ATR_DEPTH);
    len1     = CC_W'(atr_len_q) + CC_W'(1);
    cnt_full = (len1 < avail) ? len1 : avail;
  end

  always_comb begin
    s3 = {2'b00, c_q, 1'b0} + {3'b000, c_q};
    pp = {3'b000, ph_q} + {3'b000, pl_q} + {3'b000, pc_q};
    dp = (s3 >= pp) ? DIF_W'(s3 - pp) : DIF_W'(pp - s3);
    s2 = {2'b00, c_q, 1'b0};
    hl = {3'b000, h_q} + {3'b000, l_q};
    dm = (s2 >= hl) ? DIF_W'(s2 - hl) : DIF_W'(hl - s2);
    dv = (cv_q >= pv_q) ? (cv_q - pv_q) : (pv_q - cv_q);
    m3 = {msum_q, 1'b0} + {2'b00, msum_q};
  end

  assign full = (CC_W'(bs_q) >= CC_W'(VWAP_BARS));

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    h_d         = h_q;
    l_d         = l_q;
    c_d         = c_q;
    v_d         = v_q;
    ph_d        = ph_q;
    pl_d        = pl_q;
    pc_d        = pc_q;
    bs_d        = bs_q;
    tr_wp_d     = tr_wp_q;
    rd_ptr_d    = rd_ptr_q;
    vw_pos_d    = vw_pos_q;
    cnt_d       = cnt_q;
    rd_left_d   = rd_left_q;
    pend_d      = 1'b0;
    sum_d       = sum_q;
    pv_d        = pv_q;
    vs_d        = vs_q;
    cv_d        = cv_q;
    msum_d      = msum_q;
    lv_d        = lv_q;
    np_d        = np_q;
    nm_d        = nm_q;
    nv_d        = nv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    score_d     = score_q;
    atr_d       = atr_q;
    onp_d       = onp_q;
    onm_d       = onm_q;
    onv_d       = onv_q;
    tr_we       = 1'b0;
    tr_rd_en    = 1'b0;
    vw_we       = 1'b0;
    mul_go      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_go      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          h_d       = high_price_i;
          l_d       = low_price_i;
          c_d       = close_price_i;
          v_d       = bar_volume_i;
          mul_go    = 1'b1;
          mul_a     = MA_W'(close_price_i);
          mul_b     = MB_W'(bar_volume_i);
          op_d      = OP_PV;
          cnt_d     = cnt_full[CNT_W-1:0];
          rd_left_d = cnt_full[CNT_W-1:0];
          rd_ptr_d  = tr_wp_q;
          sum_d     = '0;
          if (bs_q != '0) begin
            tr_we   = 1'b1;
            tr_wp_d = (tr_wp_q == TR_AW'(ATR_DEPTH - 1)) ? '0 : tr_wp_q + 1'b1;
          end
          state_d   = S_MUL;
        end
      end

      S_SUM: begin
        if (rd_left_q != '0) begin
          tr_rd_en  = 1'b1;
          pend_d    = 1'b1;
          rd_left_d = rd_left_q - 1'b1;
          rd_ptr_d  = (rd_ptr_q == '0) ? TR_AW'(ATR_DEPTH - 1) : rd_ptr_q - 1'b1;
        end
        if (pend_q) begin
          sum_d = sum_q + TRS_W'(tr_rd_q);
        end
        if ((rd_left_q == '0) && !pend_q) begin
          div_go  = 1'b1;
          mul_go  = 1'b1;
          mul_a   = MA_W'(sum_q);
          mul_b   = MB_W'(tol_q);
          op_d    = OP_MSUM;
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        if (!mul_busy) begin
          unique case (op_q)
            OP_PV: begin
              vw_we    = 1'b1;
              vw_pos_d = (vw_pos_q == VW_AW'(VWAP_BARS - 1)) ? '0 : vw_pos_q + 1'b1;
              pv_d     = pv_q + PV_W'(prod[PE_W-1:0])
                         - (full ? PV_W'(vw_rd_q[PE_W+VOL_W-1:VOL_W]) : '0);
              vs_d     = vs_q + VS_W'(v_q) - (full ? VS_W'(vw_rd_q[VOL_W-1:0]) : '0);
              if (bs_q == '0) begin
                ph_d    = h_q;
                pl_d    = l_q;
                pc_d    = c_q;
                bs_d    = BS_W'(1);
                state_d = S_IDLE;
              end else begin
                state_d = S_SUM;
              end
            end
            OP_MSUM: begin
              msum_d = prod[MS_W-1:0];
              mul_go = 1'b1;
              mul_a  = MA_W'(c_q);
              mul_b  = vs_q;
              op_d   = OP_CV;
            end
            OP_CV: begin
              cv_d   = prod[PV_W-1:0];
              mul_go = 1'b1;
              mul_a  = MA_W'(dp);
              mul_b  = MB_W'(cnt_q);
              op_d   = OP_DP;
            end
            OP_DP: begin
              np_d   = {prod, {FRAC_W{1'b0}}} <= CMP_W'(m3);
              mul_go = 1'b1;
              mul_a  = MA_W'(dm);
              mul_b  = MB_W'(cnt_q);
              op_d   = OP_DM;
            end
            OP_DM: begin
              nm_d   = {prod, {FRAC_W{1'b0}}} <= CMP_W'({msum_q, 1'b0});
              mul_go = 1'b1;
              mul_a  = dv;
              mul_b  = MB_W'(cnt_q);
              op_d   = OP_DV;
            end
            OP_DV: begin
              lv_d   = prod;
              mul_go = 1'b1;
              mul_a  = MA_W'(msum_q);
              mul_b  = vs_q;
              op_d   = OP_RV;
            end
            OP_RV: begin
              nv_d    = (vs_q == '0) ||
                        ({lv_q, {FRAC_W{1'b0}}} <= {{FRAC_W{1'b0}}, prod});
              state_d = S_FIN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_FIN: begin
        if (!div_busy && (!out_valid_q || out_ready_i)) begin
          out_valid_d = 1'b1;
          score_d     = {1'b0, np_q} + {1'b0, nm_q} + {1'b0, nv_q};
          atr_d       = quot[ATR_W-1:0];
          onp_d       = np_q;
          onm_d       = nm_q;
          onv_d       = nv_q;
          ph_d        = h_q;
          pl_d        = l_q;
          pc_d        = c_q;
          if (bs_q != BS_W'(BS_CAP)) begin
            bs_d = bs_q + 1'b1;
          end
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_PV;
      atr_len_q   <= ATR_LEN_RST;
      tol_q       <= TOL_RST;
      ph_q        <= '0;
      pl_q        <= '0;
      pc_q        <= '0;
      bs_q        <= '0;
      tr_wp_q     <= '0;
      rd_ptr_q    <= '0;
      vw_pos_q    <= '0;
      rd_left_q   <= '0;
      pend_q      <= 1'b0;
      pv_q        <= '0;
      vs_q        <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      ph_q        <= ph_d;
      pl_q        <= pl_d;
      pc_q        <= pc_d;
      bs_q        <= bs_d;
      tr_wp_q     <= tr_wp_d;
      rd_ptr_q    <= rd_ptr_d;
      vw_pos_q    <= vw_pos_d;
      rd_left_q   <= rd_left_d;
      pend_q      <= pend_d;
      pv_q        <= pv_d;
      vs_q        <= vs_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ATR_LEN: atr_len_q <= cfg_data_i[ATRL_W-1:0];
          REG_TOL:     tol_q     <= cfg_data_i[TOL_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    l_q     <= l_d;
    c_q     <= c_d;
    v_q     <= v_d;
    cnt_q   <= cnt_d;
    cv_q    <= cv_d;
    msum_q  <= msum_d;
    lv_q    <= lv_d;
    np_q    <= np_d;
    nm_q    <= nm_d;
    nv_q    <= nv_d;
    score_q <= score_d;
    atr_q   <= atr_d;
    onp_q   <= onp_d;
    onm_q   <= onm_d;
    onv_q   <= onv_d;
  end

  // true range ring
  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      tr_mem[tr_wp_q] <= tr_val;
    end
    if (tr_rd_en) begin
      tr_rd_q <= tr_mem[rd_ptr_q];
    end
  end

  // price-volume / volume ring, oldest entry read on accept
  always_ff @(posedge clk_i) begin
    if (vw_we) begin
      vw_mem[vw_pos_q] <= {prod[PE_W-1:0], v_q};
    end
    if (accept) begin
      vw_rd_q <= vw_mem[vw_pos_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign score_o         = score_q;
  assign atr_value_o     = atr_q;
  assign near_pivot_o    = onp_q;
  assign near_midrange_o = onm_q;
  assign near_vwap_o     = onv_q;

endmodule
